// File: sv/bpra_pkg.sv
package bpra_pkg;

    localparam int ADDR_W        = 32;
    localparam int PB_W          = 23;
    localparam int PP_W          = 13;
    localparam int RUN_W         = 13;
    localparam int ST_W          = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int WORD_W        = 32;
    localparam int OFF_W         = $clog2(WORD_W);
    localparam int DIV_STEPS     = ADDR_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
    localparam int DEF_MAX_PAGES = 4096;

    localparam logic [ADDR_W-1:0] BASE_RESET = 32'd1048576;
    localparam logic [PB_W-1:0]   PAGE_RESET = 23'd4096;
    localparam logic [PP_W-1:0]   POOL_RESET = 13'd4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_ROOM = 2'd1;
    localparam logic [ST_W-1:0] ST_CLIPPED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL = 2'd2;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] dividend;
        logic [PB_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] quotient;
    } t_div_rsp;

endpackage

// File: sv/bpra_req_if.sv
interface bpra_req_if;
    import bpra_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [RUN_W-1:0]  run_pages;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, output operation, output run_pages, output free_address,
                    input ready);
    modport sink (input valid, input operation, input run_pages, input free_address,
                  output ready);
endinterface

// File: sv/bpra_rsp_if.sv
interface bpra_rsp_if;
    import bpra_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] run_address;
    logic [ST_W-1:0]   status;

    modport source (output valid, output run_address, output status, input ready);
    modport sink (input valid, input run_address, input status, output ready);
endinterface

// File: sv/bitmap_page_run_allocator.sv
// Contiguous page allocator over a used-page bitmap held in a word-wide RAM.
// Requests arrive on i_req: operation 0 allocates run_pages pages at the
// lowest fitting place, operation 1 frees the run starting at free_address.
// Each request gives one response on o_rsp with run_address and status.
// Configuration registers (base, page size, pool size) are written through
// i_cfg_we, i_cfg_index and i_cfg_data; the user must write them only while
// the block is idle, which the block itself does not enforce. One request is
// worked on at a time. An allocate scans the map a word at a time, passing
// over a wholly used word, or a wholly free one that cannot end the run, at
// once and looking at each page of any other word in turn, then marks the run
// with a read and a write per map word. A free divides the address offset by
// the page size in the restoring divider, then clears the run likewise. The
// map RAM read port sets the word pace. After reset a clearing pass writes
// every map word, one a cycle; no request is accepted meanwhile. The response
// sits in an output register, so the next request is accepted while it waits.
// If the receiver stalls, a finished request waits for the register to free.
module bitmap_page_run_allocator #(
    parameter int MAX_PAGES = bpra_pkg::DEF_MAX_PAGES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpra_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpra_pkg::ADDR_W-1:0]    i_cfg_data,
    bpra_req_if.sink                       i_req,
    bpra_rsp_if.source                     o_rsp
);
    import bpra_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    localparam int CW     = (CNT_W > RUN_W) ? CNT_W : RUN_W;
    localparam int SUM_W  = ((CNT_W > OFF_W) ? CNT_W : OFF_W) + 1;
    localparam int NWORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
    localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_A_RD   = 8'b0000_0100,
        S_A_SCAN = 8'b0000_1000,
        S_DIV    = 8'b0001_0000,
        S_M_RD   = 8'b0010_0000,
        S_M_WR   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [ADDR_W-1:0] r_base;
    logic [PB_W-1:0]   r_page_bytes;
    logic [PP_W-1:0]   r_pool_pages;

    logic [CNT_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_run;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_lo;
    logic [CNT_W-1:0]  r_hi;
    logic [WA_W-1:0]   r_wa;
    logic [RUN_W-1:0]  r_req_run;
    logic              r_set;
    logic [ST_W-1:0]   r_status;
    logic [ADDR_W-1:0] r_prod;

    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic [ST_W-1:0]   r_out_status;

    logic [CW-1:0]     w_pool;
    logic [CNT_W-1:0]  w_pool_c;
    logic [PB_W-1:0]   w_psize;
    logic              w_accept;
    logic              w_load_out;

    logic              w_rd_en;
    logic [WA_W-1:0]   w_rd_addr;
    logic              w_wr_en;
    logic [WA_W-1:0]   w_wr_addr;
    logic [WORD_W-1:0] w_wr_data;
    logic [WORD_W-1:0] w_q;

    logic [OFF_W-1:0]  w_off;
    logic [SUM_W-1:0]  w_pos_w;
    logic [SUM_W-1:0]  w_run_w;
    logic              w_skip_free;
    logic              w_skip_used;
    logic              w_bit;
    logic [CNT_W-1:0]  w_run_inc;
    logic              w_found;
    logic [CNT_W-1:0]  w_first;

    logic [WA_W-1:0]   w_lo_wa;
    logic [WA_W-1:0]   w_hi_wa;
    logic [OFF_W-1:0]  w_lo_off;
    logic [OFF_W-1:0]  w_hi_off;
    logic [WORD_W-1:0] w_mask;

    logic [ADDR_W:0]   w_end;
    logic [ADDR_W:0]   w_pool_e;
    logic [ADDR_W:0]   w_end_c;
    logic              w_clip;
    logic              w_any;

    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    assign w_pool   = (CW'(r_pool_pages) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(r_pool_pages);
    assign w_pool_c = CNT_W'(w_pool);
    assign w_psize  = (r_page_bytes == '0) ? PB_W'(1) : r_page_bytes;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    assign w_div_req.start    = w_accept && (i_req.operation == OP_FREE);
    assign w_div_req.dividend = i_req.free_address - r_base;
    assign w_div_req.divisor  = w_psize;

    bpra_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    bpra_map_ram #(
        .DEPTH (NWORDS),
        .AW    (WA_W)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_q)
    );

    assign w_off       = OFF_W'(r_pos);
    assign w_pos_w     = SUM_W'(r_pos) + SUM_W'(WORD_W);
    assign w_run_w     = SUM_W'(r_run) + SUM_W'(WORD_W);
    assign w_skip_free = (w_off == '0) && (w_q == '0) && (w_pos_w <= SUM_W'(w_pool_c))
                         && (w_run_w < SUM_W'(r_count));
    assign w_skip_used = (w_off == '0) && (w_q == '1) && (w_pos_w <= SUM_W'(w_pool_c));
    assign w_bit       = w_q[w_off];
    assign w_run_inc   = r_run + CNT_W'(1);
    assign w_found     = !w_bit && (w_run_inc == r_count);
    assign w_first     = r_pos + CNT_W'(1) - r_count;

    assign w_lo_wa  = WA_W'(r_lo >> OFF_W);
    assign w_hi_wa  = WA_W'(r_hi >> OFF_W);
    assign w_lo_off = (r_wa == w_lo_wa) ? OFF_W'(r_lo) : '0;
    assign w_hi_off = (r_wa == w_hi_wa) ? OFF_W'(r_hi) : '1;
    assign w_mask   = ({WORD_W{1'b1}} << w_lo_off)
                      & ({WORD_W{1'b1}} >> (OFF_W'(WORD_W - 1) - w_hi_off));

    assign w_end    = {1'b0, w_div_rsp.quotient} + (ADDR_W + 1)'(r_req_run);
    assign w_pool_e = (ADDR_W + 1)'(w_pool_c);
    assign w_clip   = w_end > w_pool_e;
    assign w_end_c  = w_clip ? w_pool_e : w_end;
    assign w_any    = {1'b0, w_div_rsp.quotient} < w_end_c;

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_wa;
        w_wr_en   = 1'b0;
        w_wr_addr = r_wa;
        w_wr_data = r_set ? (w_q | w_mask) : (w_q & ~w_mask);
        unique case (r_state)
            S_A_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = WA_W'(r_pos >> OFF_W);
            end
            S_M_RD: begin
                w_rd_en = 1'b1;
            end
            S_M_WR: begin
                w_wr_en = 1'b1;
            end
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_data = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_wa == WA_W'(NWORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.operation == OP_FREE) begin
                        n_state = S_DIV;
                    end else if ((i_req.run_pages == '0) || (CW'(i_req.run_pages) > w_pool)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_A_RD;
                    end
                end
            end
            S_A_RD: begin
                n_state = S_A_SCAN;
            end
            S_A_SCAN: begin
                if (r_pos >= w_pool_c) begin
                    n_state = S_DONE;
                end else if (w_skip_free || w_skip_used) begin
                    n_state = S_A_RD;
                end else if (w_found) begin
                    n_state = S_M_RD;
                end else if (w_off == OFF_W'(WORD_W - 1)) begin
                    n_state = S_A_RD;
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = w_any ? S_M_RD : S_DONE;
                end
            end
            S_M_RD: begin
                n_state = S_M_WR;
            end
            S_M_WR: begin
                n_state = (r_wa == w_hi_wa) ? S_DONE : S_M_RD;
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_wa         <= '0;
            r_out_valid  <= 1'b0;
            r_base       <= BASE_RESET;
            r_page_bytes <= PAGE_RESET;
            r_pool_pages <= POOL_RESET;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BASE: r_base       <= i_cfg_data;
                    CFG_PAGE: r_page_bytes <= PB_W'(i_cfg_data);
                    CFG_POOL: r_pool_pages <= PP_W'(i_cfg_data);
                    default: begin
                    end
                endcase
            end

            if (w_load_out) begin
                r_out_valid  <= 1'b1;
                r_out_addr   <= r_set ? (r_base + r_prod) : '0;
                r_out_status <= r_status;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_wa <= r_wa + WA_W'(1);
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_req_run <= i_req.run_pages;
                        r_count   <= CNT_W'(i_req.run_pages);
                        r_pos     <= '0;
                        r_run     <= '0;
                        r_set     <= (i_req.operation == OP_ALLOC);
                        r_status  <= ST_DONE;
                        if ((i_req.operation == OP_ALLOC) && ((i_req.run_pages == '0)
                                || (CW'(i_req.run_pages) > w_pool))) begin
                            r_set    <= 1'b0;
                            r_status <= ST_NO_ROOM;
                        end
                    end
                end
                S_A_SCAN: begin
                    if (r_pos >= w_pool_c) begin
                        r_set    <= 1'b0;
                        r_status <= ST_NO_ROOM;
                    end else if (w_skip_free) begin
                        r_run <= CNT_W'(w_run_w);
                        r_pos <= CNT_W'(w_pos_w);
                    end else if (w_skip_used) begin
                        r_run <= '0;
                        r_pos <= CNT_W'(w_pos_w);
                    end else if (w_found) begin
                        r_lo <= w_first;
                        r_hi <= r_pos;
                        r_wa <= WA_W'(w_first >> OFF_W);
                    end else begin
                        r_run <= w_bit ? '0 : w_run_inc;
                        r_pos <= r_pos + CNT_W'(1);
                    end
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_status <= w_clip ? ST_CLIPPED : ST_DONE;
                        r_lo     <= CNT_W'(w_div_rsp.quotient);
                        r_hi     <= CNT_W'(w_end_c - (ADDR_W + 1)'(1));
                        r_wa     <= WA_W'(w_div_rsp.quotient >> OFF_W);
                    end
                end
                S_M_RD: begin
                    r_prod <= ADDR_W'(r_lo * w_psize);
                end
                S_M_WR: begin
                    r_wa <= r_wa + WA_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.run_address = r_out_addr;
    assign o_rsp.status      = r_out_status;

`ifndef SYNTHESIS
    a_wr_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_M_WR || r_state == S_CLEAR))
        else $error("map written outside a marking or clearing state");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_SCAN) |-> (r_pos <= w_pool_c))
        else $error("scan position beyond the pool end");

    a_noroom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_NO_ROOM) |-> (o_rsp.run_address == '0))
        else $error("failed allocation returned a non-zero address");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside a free request");

    a_mark_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M_WR) |-> (r_lo <= r_hi && r_wa <= w_hi_wa && r_wa >= w_lo_wa))
        else $error("marking beyond the run");
`endif
endmodule

// File: sv/bpra_divider.sv
module bpra_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bpra_pkg::t_div_req  i_req,
    output bpra_pkg::t_div_rsp  o_rsp
);
    import bpra_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PB_W-1:0]      r_rem;
    logic [ADDR_W-1:0]    r_quo;
    logic [PB_W-1:0]      r_div;
    logic [PB_W:0]        w_trial;
    logic                 w_fit;

    assign w_trial = {r_rem, r_quo[ADDR_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= w_fit ? PB_W'(w_trial - {1'b0, r_div}) : PB_W'(w_trial);
                r_quo <= {r_quo[ADDR_W-2:0], w_fit};
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

// File: sv/bpra_map_ram.sv
module bpra_map_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [bpra_pkg::WORD_W-1:0] i_wr_data,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [bpra_pkg::WORD_W-1:0] o_rd_data
);
    import bpra_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;
endmodule

// File: tb/bitmap_page_run_allocator_tb.sv
`timescale 1ns / 1ps

module bitmap_page_run_allocator_tb;
    import bpra_pkg::*;

    localparam int MAX_PAGES   = DEF_MAX_PAGES;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 200;
    localparam int PHASES      = 7;

    typedef struct packed {
        logic              operation;
        logic [RUN_W-1:0]  run_pages;
        logic [ADDR_W-1:0] free_address;
    } page_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] run_address;
        logic [ST_W-1:0]   status;
    } page_rsp_t;

    typedef struct {
        page_req_t req;
        bit        typed;
        page_rsp_t rsp;
    } stim_row_t;

    typedef struct {
        logic [ADDR_W-1:0] address;
        int unsigned       pages;
    } live_run_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ADDR_W-1:0]    i_cfg_data;

    bpra_req_if req_if ();
    bpra_rsp_if rsp_if ();

    bitmap_page_run_allocator #(
        .MAX_PAGES(MAX_PAGES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    logic [ADDR_W-1:0] pool_base  = BASE_RESET;
    logic [PB_W-1:0]   page_bytes = PAGE_RESET;
    logic [PP_W-1:0]   pool_pages = POOL_RESET;
    bit                page_used [MAX_PAGES];

    page_rsp_t   predicted_results [$];
    live_run_t   live_runs [$];
    stim_row_t   directed_rows [$];
    int unsigned mismatch_count = 0;
    int unsigned tx_idle_pct    = 6;
    int unsigned rx_idle_pct    = 78;
    bit          hold_request   = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned usable_pages();
        return (pool_pages > MAX_PAGES) ? MAX_PAGES : pool_pages;
    endfunction

    function automatic int unsigned page_span();
        return (page_bytes == '0) ? 1 : page_bytes;
    endfunction

    // Updates the page map as the block would and returns the response it owes.
    function automatic page_rsp_t predict_request(page_req_t r);
        int unsigned       pool;
        int unsigned       span;
        int unsigned       free_len;
        int unsigned       first;
        int unsigned       p;
        bit                found;
        logic [ADDR_W-1:0] offset;
        longint unsigned   index;
        longint unsigned   stop;
        longint unsigned   k;
        page_rsp_t         res;
        pool = usable_pages();
        span = page_span();
        res.run_address = '0;
        if (r.operation == OP_ALLOC) begin
            res.status = ST_NO_ROOM;
            free_len = 0;
            found = 1'b0;
            if (r.run_pages != 0 && r.run_pages <= pool) begin
                for (p = 0; p < pool && !found; p++) begin
                    free_len = page_used[p] ? 0 : free_len + 1;
                    if (free_len == r.run_pages) begin
                        found = 1'b1;
                        first = p + 1 - r.run_pages;
                        for (k = first; k <= p; k++) begin
                            page_used[k] = 1'b1;
                        end
                        res.run_address = pool_base + first * span;
                        res.status = ST_DONE;
                    end
                end
            end
        end else begin
            offset = r.free_address - pool_base;
            index = offset / span;
            stop = index + r.run_pages;
            res.status = ST_DONE;
            if (stop > pool) begin
                stop = pool;
                res.status = ST_CLIPPED;
            end
            for (k = index; k < stop; k++) begin
                page_used[k] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic stim_row_t stim_row(logic op, int unsigned pages,
                                           logic [ADDR_W-1:0] addr, bit typed,
                                           logic [ADDR_W-1:0] exp_addr,
                                           logic [ST_W-1:0] exp_status);
        stim_row_t row;
        row.req.operation    = op;
        row.req.run_pages    = pages;
        row.req.free_address = addr;
        row.typed            = typed;
        row.rsp.run_address  = exp_addr;
        row.rsp.status       = exp_status;
        return row;
    endfunction

    // Mostly allocations and frees of runs still held, with some noise mixed in.
    function automatic page_req_t next_random_request();
        int unsigned pick;
        int unsigned slot;
        live_run_t   victim;
        page_req_t   r;
        pick = $urandom_range(99);
        r.operation = OP_ALLOC;
        r.run_pages = $urandom_range(1, 8);
        r.free_address = $urandom;
        if (pick < 8) begin
            r.operation = $urandom_range(1);
            r.run_pages = $urandom_range(8191);
        end else if (live_runs.size() > 40 || (pick < 52 && live_runs.size() > 0)) begin
            slot = $urandom_range(live_runs.size() - 1);
            victim = live_runs[slot];
            live_runs.delete(slot);
            r.operation = OP_FREE;
            r.run_pages = ($urandom_range(9) == 0) ? $urandom_range(victim.pages)
                                                   : victim.pages;
            r.free_address = victim.address +
                (($urandom_range(3) == 0) ? $urandom_range(page_span() - 1) : 0);
        end else if (pick < 56) begin
            r.run_pages = $urandom_range(usable_pages() + 2);
        end
        return r;
    endfunction

    task automatic send_request(page_req_t r, bit typed, page_rsp_t typed_rsp);
        page_rsp_t expected;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.operation    <= r.operation;
        req_if.run_pages    <= r.run_pages;
        req_if.free_address <= r.free_address;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        expected = predict_request(r);
        if (r.operation == OP_ALLOC && expected.status == ST_DONE) begin
            live_runs.push_back('{expected.run_address, r.run_pages});
        end
        predicted_results.push_back(typed ? typed_rsp : expected);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (predicted_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [ADDR_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_BASE: pool_base  = value;
            CFG_PAGE: page_bytes = value[PB_W-1:0];
            CFG_POOL: pool_pages = value[PP_W-1:0];
            default: ;
        endcase
    endtask

    initial begin : response_sink
        int unsigned stall_left;
        stall_left = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : response_check
        page_rsp_t expected;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (predicted_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: response %h status %0d with no request outstanding",
                         $time, rsp_if.run_address, rsp_if.status);
            end else begin
                expected = predicted_results.pop_front();
                if (rsp_if.run_address !== expected.run_address) begin
                    mismatch_count++;
                    $display("%0t: run_address expected %h, got %h",
                             $time, expected.run_address, rsp_if.run_address);
                end
                if (rsp_if.status !== expected.status) begin
                    mismatch_count++;
                    $display("%0t: status expected %0d, got %0d",
                             $time, expected.status, rsp_if.status);
                end
            end
        end
    end

    initial begin : stimulus
        int                phase;
        int                n;
        int                items;
        logic [ADDR_W-1:0] new_base;
        logic [ADDR_W-1:0] new_page;
        logic [ADDR_W-1:0] new_pool;
        page_req_t         req;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = CFG_BASE;
        i_cfg_data          = '0;
        req_if.valid        = 1'b0;
        req_if.operation    = OP_ALLOC;
        req_if.run_pages    = '0;
        req_if.free_address = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: pages of 4 KiB from 1 MiB upwards, 4096 of them.
        directed_rows.push_back(stim_row(OP_ALLOC, 0, 0, 1, 0, ST_NO_ROOM));
        directed_rows.push_back(stim_row(OP_ALLOC, 8191, 0, 1, 0, ST_NO_ROOM));
        directed_rows.push_back(stim_row(OP_ALLOC, 4097, 0, 1, 0, ST_NO_ROOM));
        directed_rows.push_back(stim_row(OP_ALLOC, 4096, 0, 1, 32'h0010_0000, ST_DONE));
        directed_rows.push_back(stim_row(OP_ALLOC, 1, 0, 1, 0, ST_NO_ROOM));
        directed_rows.push_back(stim_row(OP_FREE, 4096, 32'h0010_0000, 1, 0, ST_DONE));
        directed_rows.push_back(stim_row(OP_ALLOC, 1, 0, 1, 32'h0010_0000, ST_DONE));
        directed_rows.push_back(stim_row(OP_ALLOC, 3, 0, 1, 32'h0010_1000, ST_DONE));
        directed_rows.push_back(stim_row(OP_ALLOC, 2, 0, 1, 32'h0010_4000, ST_DONE));
        directed_rows.push_back(stim_row(OP_FREE, 1, 32'h0010_0000, 1, 0, ST_DONE));
        directed_rows.push_back(stim_row(OP_ALLOC, 2, 0, 0, 0, ST_DONE));
        directed_rows.push_back(stim_row(OP_FREE, 3, 32'h0010_1FFF, 1, 0, ST_DONE));
        directed_rows.push_back(stim_row(OP_FREE, 3, 32'h0010_1000, 1, 0, ST_DONE));
        directed_rows.push_back(stim_row(OP_ALLOC, 4, 32'hFFFF_FFFF, 0, 0, ST_DONE));
        directed_rows.push_back(stim_row(OP_FREE, 1, 32'h0000_0000, 1, 0, ST_CLIPPED));
        directed_rows.push_back(stim_row(OP_FREE, 8191, 32'hFFFF_FFFF, 1, 0, ST_CLIPPED));
        directed_rows.push_back(stim_row(OP_FREE, 2, 32'h010F_F000, 1, 0, ST_CLIPPED));
        directed_rows.push_back(stim_row(OP_FREE, 0, 32'h0148_8000, 1, 0, ST_CLIPPED));
        directed_rows.push_back(stim_row(OP_FREE, 0, 32'h0110_0000, 1, 0, ST_DONE));
        directed_rows.push_back(stim_row(OP_ALLOC, 1, 0, 0, 0, ST_DONE));
        directed_rows.push_back(stim_row(OP_FREE, 4096, 32'h0010_0000, 1, 0, ST_DONE));
        directed_rows.push_back(stim_row(OP_ALLOC, 8, 0, 1, 32'h0010_0000, ST_DONE));
        directed_rows.push_back(stim_row(OP_FREE, 4096, 32'h0010_0000, 1, 0, ST_DONE));

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    new_base = '0; new_page = 1; new_pool = 64; items = 200;
                end
                1: begin
                    // The second page lands on address zero once the sum wraps.
                    new_base = 32'hFFC0_0000; new_page = 4194304; new_pool = 16; items = 150;
                end
                2: begin
                    new_base = $urandom; new_page = 0; new_pool = 8191; items = 200;
                end
                3: begin
                    new_base = $urandom; new_page = $urandom_range(1, 4194304);
                    new_pool = 0; items = 60;
                end
                4: begin
                    new_base = $urandom; new_page = $urandom_range(1, 65536);
                    new_pool = 4096; items = 200;
                end
                5: begin
                    new_base = 32'hFFFF_FFFF; new_page = 32'h007F_FFFF;
                    new_pool = $urandom_range(1, 300); items = 200;
                end
                default: begin
                    new_base = $urandom; new_page = 4096;
                    new_pool = $urandom_range(8, 200); items = 200;
                end
            endcase
            drain_results();
            write_register(CFG_BASE, new_base);
            write_register(CFG_PAGE, new_page);
            write_register(CFG_POOL, new_pool);
            live_runs.delete();
            case (phase % 3)
                0: begin tx_idle_pct = 6;  rx_idle_pct = 78; end
                1: begin tx_idle_pct = 78; rx_idle_pct = 6;  end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            send_request('{OP_FREE, 13'd4096, pool_base}, 1'b0, '0);
            for (n = 0; n < items; n++) begin
                if (phase == 2 && n == 40) begin
                    hold_request = 1'b1;
                end
                if (phase == 4 && n == 100) begin
                    drain_results();
                end
                req = next_random_request();
                send_request(req, 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("bitmap_page_run_allocator_tb passed");
        end else begin
            $display("bitmap_page_run_allocator_tb failed");
        end
        $finish;
    end

    initial begin
        #300_000_000;
        $display("%0t: timed out with %0d responses outstanding",
                 $time, predicted_results.size());
        $display("bitmap_page_run_allocator_tb failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/bpra_pkg.sv
sv/bpra_req_if.sv
sv/bpra_rsp_if.sv
sv/bpra_divider.sv
sv/bpra_map_ram.sv
sv/bitmap_page_run_allocator.sv
tb/bitmap_page_run_allocator_tb.sv
